// File: src/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg: shared definitions for the rectangle area average block
// Field widths, register indexes, action codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rra_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W   = 16;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 4 * CH_W;
	localparam int REG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Default image store dimensions.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// Image size held in both size registers after reset.
	localparam int RESET_SIZE = 256;

	// Restoring divide steps: one per quotient bit of an 8-bit average.
	localparam int DIV_STEPS = CH_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Action codes of an input transaction.
	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_accept;
		logic capture;
		logic order;
		logic clamp;
		logic setup;
		logic walk;
		logic div_step;
		logic load_result;
	} rra_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic outside;
		logic walk_last;
	} rra_sts_t;

endpackage

// File: src/rectangle_area_average_top.sv
// ----------------------------------------------------------------------------
// rectangle_area_average_top: RGBA8 rectangle area average
// Pixel store with a write path and a rectangle query that sums each channel
// over the clamped rectangle and divides by the pixel count.
// ----------------------------------------------------------------------------
// Write transaction: one per cycle while no query is in flight; the pixel
// is registered and lands in the store in the following cycle.
// Query: the store port reads one pixel per cycle of the walk, the divider
// resolves one quotient bit per cycle; an outside rectangle skips both.
// A new transaction is taken when no query is in flight.
// Reset clears control state and sets both sizes to 256, capped at the store
// size; the store is not cleared and holds undefined data until written.
module rectangle_area_average_top #(
	parameter int MAX_WIDTH  = rra_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rra_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rra_pkg::REG_W-1:0]           cfg_data,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                action,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_a_x,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_a_y,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_b_x,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_b_y,
	input  logic [rra_pkg::CH_W-1:0]            in_red,
	input  logic [rra_pkg::CH_W-1:0]            in_green,
	input  logic [rra_pkg::CH_W-1:0]            in_blue,
	input  logic [rra_pkg::CH_W-1:0]            in_alpha,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [rra_pkg::CH_W-1:0]            avg_red,
	output logic [rra_pkg::CH_W-1:0]            avg_green,
	output logic [rra_pkg::CH_W-1:0]            avg_blue,
	output logic [rra_pkg::CH_W-1:0]            avg_alpha,
	output logic                                outside
);

	rra_pkg::rra_cmd_t cmd;
	rra_pkg::rra_sts_t sts;

	// Sequencer.
	rra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.action   (action),
		.req_ready(req_ready),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath with the pixel store.
	rra_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.corner_a_x(corner_a_x),
		.corner_a_y(corner_a_y),
		.corner_b_x(corner_b_x),
		.corner_b_y(corner_b_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue),
		.avg_alpha (avg_alpha),
		.outside   (outside),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: src/rra_ram.sv
// ----------------------------------------------------------------------------
// rra_ram: generic single-port RAM
// One optional write and one read per cycle at a shared address, read data registered.
// ----------------------------------------------------------------------------
module rra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port share the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: src/rra_ctrl.sv
// ----------------------------------------------------------------------------
// rra_ctrl: sequencer for the rectangle area average block
// Accepts transactions, steps a query through ordering, clamping, the pixel
// walk and the divide, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              action,
	output logic              req_ready,
	input  logic              res_ready,
	output logic              res_valid,
	output rra_pkg::rra_cmd_t cmd,
	input  rra_pkg::rra_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ORDER,
		S_CLAMP,
		S_SETUP,
		S_WALK,
		S_DRAIN,
		S_DIV,
		S_FINISH
	} state_t;

	state_t                      state_q;
	logic [rra_pkg::DIV_CW-1:0]  div_cnt_q;
	logic                        res_valid_q;
	logic                        accept;
	logic                        load;

	// A transaction is taken only between queries; writes stream freely.
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign load      = (state_q == S_FINISH) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd             = '0;
		cmd.wr_accept   = accept && (action == rra_pkg::ACTION_WRITE);
		cmd.capture     = accept && (action == rra_pkg::ACTION_QUERY);
		cmd.order       = (state_q == S_ORDER);
		cmd.clamp       = (state_q == S_CLAMP);
		cmd.setup       = (state_q == S_SETUP);
		cmd.walk        = (state_q == S_WALK);
		cmd.div_step    = (state_q == S_DIV);
		cmd.load_result = load;
	end

	// State, divide step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (action == rra_pkg::ACTION_QUERY)) begin
						state_q <= S_ORDER;
					end
				end
				S_ORDER: begin
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					state_q <= sts.outside ? S_FINISH : S_WALK;
				end
				S_WALK: begin
					if (sts.walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q   <= S_DIV;
					div_cnt_q <= rra_pkg::DIV_CW'(rra_pkg::DIV_STEPS - 1);
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				S_FINISH: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
			endcase

			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// An accepted query always starts the ordering step.
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == rra_pkg::ACTION_QUERY)) |=> (state_q == S_ORDER))
		else $error("accepted query did not start");

	// The last divide step hands over to the result stage.
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && (div_cnt_q == '0)) |=> (state_q == S_FINISH))
		else $error("divide did not finish after its last step");

	// A finished result waits while the previous one is still pending.
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINISH) && res_valid_q && !res_ready) |=>
		((state_q == S_FINISH) && res_valid_q))
		else $error("result overwritten before it was taken");

endmodule

// File: src/rra_datapath.sv
// ----------------------------------------------------------------------------
// rra_datapath: datapath of the rectangle area average block
// Size registers, pixel store, corner ordering and clamping, the pixel walk
// with per-channel accumulators and a four-lane restoring divider.
// ----------------------------------------------------------------------------
module rra_datapath #(
	parameter int MAX_WIDTH  = rra_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rra_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rra_pkg::REG_W-1:0]           cfg_data,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_a_x,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_a_y,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_b_x,
	input  logic signed [rra_pkg::COORD_W-1:0]  corner_b_y,
	input  logic [rra_pkg::CH_W-1:0]            in_red,
	input  logic [rra_pkg::CH_W-1:0]            in_green,
	input  logic [rra_pkg::CH_W-1:0]            in_blue,
	input  logic [rra_pkg::CH_W-1:0]            in_alpha,
	output logic [rra_pkg::CH_W-1:0]            avg_red,
	output logic [rra_pkg::CH_W-1:0]            avg_green,
	output logic [rra_pkg::CH_W-1:0]            avg_blue,
	output logic [rra_pkg::CH_W-1:0]            avg_alpha,
	output logic                                outside,
	input  rra_pkg::rra_cmd_t                   cmd,
	output rra_pkg::rra_sts_t                   sts
);

	localparam int CW    = rra_pkg::COORD_W;
	localparam int CH_W  = rra_pkg::CH_W;
	localparam int REG_W = rra_pkg::REG_W;
	localparam int WCW   = $clog2(MAX_WIDTH + 1);
	localparam int HCW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EW    = (WCW > REG_W) ? WCW : REG_W;
	localparam int EH    = (HCW > REG_W) ? HCW : REG_W;
	localparam int CNTW  = WCW + HCW;
	localparam int SUMW  = CNTW + CH_W;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW1   = CW + 1;
	localparam int RST_W = (rra_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : rra_pkg::RESET_SIZE;
	localparam int RST_H = (rra_pkg::RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT :
		rra_pkg::RESET_SIZE;
	localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

	// Effective image size.
	logic [WCW-1:0]        w_eff_q;
	logic [HCW-1:0]        h_eff_q;
	logic [WCW-1:0]        w_next;
	logic [HCW-1:0]        h_next;
	logic [EW-1:0]         cfg_w_ext;
	logic [EH-1:0]         cfg_h_ext;
	logic signed [CW1-1:0] w_s;
	logic signed [CW1-1:0] h_s;
	logic [XW-1:0]         w_last;
	logic [YW-1:0]         h_last;

	// Pixel write stage.
	logic                          wr_hit;
	logic                          we_s1;
	logic [XW-1:0]                 wx_s1;
	logic [YW-1:0]                 wy_s1;
	logic [rra_pkg::PIX_W-1:0]     wdata_s1;

	// Query corners.
	logic signed [CW-1:0] qax_q, qay_q, qbx_q, qby_q;
	logic signed [CW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic signed [CW1-1:0] lo_x_e, hi_x_e, lo_y_e, hi_y_e;
	logic                 outside_q;
	logic [XW-1:0]        x0_q, x1_q, cx_q;
	logic [YW-1:0]        y0_q, y1_q, cy_q;
	logic [AW-1:0]        row_q;

	// Accumulate and divide.
	logic [WCW-1:0]        dx;
	logic [HCW-1:0]        dy;
	logic [CNTW-1:0]       prod;
	logic [SUMW-1:0]       div_q;
	logic [SUMW-1:0]       sum_q [4];
	logic [CH_W-1:0]       quo_q [4];
	logic                  rd_v_q;

	// Memory port and result.
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;
	logic [AW-1:0]             ram_addr;
	logic [rra_pkg::PIX_W-1:0] rdata;
	logic [CH_W-1:0]           res_avg_q [4];
	logic                      res_out_q;

	// Size register decode: zero means one, too large saturates.
	always_comb begin
		cfg_w_ext = EW'(cfg_data);
		cfg_h_ext = EH'(cfg_data);
		if (cfg_data == '0) begin
			w_next = WCW'(1);
			h_next = HCW'(1);
		end else begin
			w_next = (cfg_w_ext > EW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(cfg_w_ext);
			h_next = (cfg_h_ext > EH'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : HCW'(cfg_h_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= WCW'(RST_W);
			h_eff_q <= HCW'(RST_H);
		end else if (cfg_we) begin
			if (cfg_index == rra_pkg::REG_IMAGE_WIDTH) begin
				w_eff_q <= w_next;
			end
			if (cfg_index == rra_pkg::REG_IMAGE_HEIGHT) begin
				h_eff_q <= h_next;
			end
		end
	end

	assign w_s    = $signed({{(CW1 - WCW){1'b0}}, w_eff_q});
	assign h_s    = $signed({{(CW1 - HCW){1'b0}}, h_eff_q});
	assign w_last = XW'(w_eff_q - WCW'(1));
	assign h_last = YW'(h_eff_q - HCW'(1));

	// Pixel writes inside the image are registered and stored in the next cycle.
	assign wr_hit = cmd.wr_accept &&
		(corner_a_x >= 0) && ($signed({corner_a_x[CW-1], corner_a_x}) < w_s) &&
		(corner_a_y >= 0) && ($signed({corner_a_y[CW-1], corner_a_y}) < h_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= wr_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			wx_s1    <= corner_a_x[XW-1:0];
			wy_s1    <= corner_a_y[YW-1:0];
			wdata_s1 <= {in_alpha, in_blue, in_green, in_red};
		end
	end

	// Corner capture, ordering and clamping.
	assign lo_x_e = $signed({lo_x_q[CW-1], lo_x_q});
	assign hi_x_e = $signed({hi_x_q[CW-1], hi_x_q});
	assign lo_y_e = $signed({lo_y_q[CW-1], lo_y_q});
	assign hi_y_e = $signed({hi_y_q[CW-1], hi_y_q});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qax_q <= corner_a_x;
			qay_q <= corner_a_y;
			qbx_q <= corner_b_x;
			qby_q <= corner_b_y;
		end
		if (cmd.order) begin
			lo_x_q <= (qbx_q < qax_q) ? qbx_q : qax_q;
			hi_x_q <= (qbx_q < qax_q) ? qax_q : qbx_q;
			lo_y_q <= (qby_q < qay_q) ? qby_q : qay_q;
			hi_y_q <= (qby_q < qay_q) ? qay_q : qby_q;
		end
		if (cmd.clamp) begin
			outside_q <= (hi_x_q < 0) || (lo_x_e >= w_s) || (hi_y_q < 0) || (lo_y_e >= h_s);
			x0_q <= (lo_x_q < 0) ? '0 : lo_x_q[XW-1:0];
			x1_q <= (hi_x_e >= w_s) ? w_last : hi_x_q[XW-1:0];
			y0_q <= (lo_y_q < 0) ? '0 : lo_y_q[YW-1:0];
			y1_q <= (hi_y_e >= h_s) ? h_last : hi_y_q[YW-1:0];
		end
	end

	// Pixel count of the clamped rectangle.
	assign dx   = WCW'(x1_q) - WCW'(x0_q) + WCW'(1);
	assign dy   = HCW'(y1_q) - HCW'(y0_q) + HCW'(1);
	assign prod = CNTW'(dx) * CNTW'(dy);

	// Walk counters: one pixel address per cycle, row by row.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			cx_q  <= x0_q;
			cy_q  <= y0_q;
			row_q <= AW'(y0_q) * ROW_STEP;
		end else if (cmd.walk) begin
			if (cx_q == x1_q) begin
				cx_q  <= x0_q;
				cy_q  <= cy_q + 1'b1;
				row_q <= row_q + ROW_STEP;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	assign sts.walk_last = (cx_q == x1_q) && (cy_q == y1_q);
	assign sts.outside   = outside_q;

	// Pixel store: writes and walk reads never overlap.
	assign waddr    = AW'(wy_s1) * ROW_STEP + AW'(wx_s1);
	assign raddr    = row_q + AW'(cx_q);
	assign ram_addr = we_s1 ? waddr : raddr;

	rra_ram #(
		.WIDTH(rra_pkg::PIX_W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (we_s1),
		.addr (ram_addr),
		.wdata(wdata_s1),
		.rdata(rdata)
	);

	// Read data arrives in the cycle after its address; rd_v_q flags it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= cmd.walk;
		end
	end

	// Channel sums, then a restoring divide; the sums become remainders.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			div_q <= SUMW'(prod) << (CH_W - 1);
			for (int c = 0; c < 4; c++) begin
				sum_q[c] <= '0;
				quo_q[c] <= '0;
			end
		end else if (rd_v_q) begin
			for (int c = 0; c < 4; c++) begin
				sum_q[c] <= sum_q[c] + SUMW'(rdata[c*CH_W +: CH_W]);
			end
		end else if (cmd.div_step) begin
			div_q <= div_q >> 1;
			for (int c = 0; c < 4; c++) begin
				if (sum_q[c] >= div_q) begin
					sum_q[c] <= sum_q[c] - div_q;
					quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b0};
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_out_q <= outside_q;
			for (int c = 0; c < 4; c++) begin
				res_avg_q[c] <= outside_q ? '0 : quo_q[c];
			end
		end
	end

	assign avg_red   = res_avg_q[0];
	assign avg_green = res_avg_q[1];
	assign avg_blue  = res_avg_q[2];
	assign avg_alpha = res_avg_q[3];
	assign outside   = res_out_q;

	// The walk stays inside the clamped rectangle.
	a_walk_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> ((cx_q >= x0_q) && (cx_q <= x1_q) && (cy_q >= y0_q) && (cy_q <= y1_q)))
		else $error("walk left the clamped rectangle");

	// A stored pixel write never takes the port from a walk read.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we_s1 |-> (!cmd.walk && !rd_v_q))
		else $error("pixel write collided with a walk read");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rectangle area average block
// Fills the pixel store for a series of image sizes, then mixes pixel writes
// with rectangle queries. A scoreboard keeps its own copy of the image and
// predicts the average and outside flag that each query returns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COORD_W    = rra_pkg::COORD_W;
	localparam int CH_W       = rra_pkg::CH_W;
	localparam int PIX_W      = rra_pkg::PIX_W;
	localparam int REG_W      = rra_pkg::REG_W;
	localparam int CFG_IDX_W  = rra_pkg::CFG_IDX_W;
	localparam int RESET_SIZE = rra_pkg::RESET_SIZE;
	localparam logic ACTION_WRITE = rra_pkg::ACTION_WRITE;
	localparam logic ACTION_QUERY = rra_pkg::ACTION_QUERY;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = rra_pkg::REG_IMAGE_WIDTH;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = rra_pkg::REG_IMAGE_HEIGHT;

	localparam int STORE_W     = rra_pkg::DEF_MAX_WIDTH;
	localparam int STORE_H     = rra_pkg::DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int DRAIN_WAIT  = 20;
	localparam int IDLE_PCT    = 37;
	localparam int NUM_PHASES  = 8;
	localparam int ITEMS_PER_PHASE = 40;

	// One input transaction as the bench sees it.
	typedef struct {
		logic                      action;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic [CH_W-1:0]           red;
		logic [CH_W-1:0]           green;
		logic [CH_W-1:0]           blue;
		logic [CH_W-1:0]           alpha;
	} pixel_req_t;

	// One result transaction.
	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            outside;
	} area_avg_t;

	// Image model and queue of averages still owed by the block.
	class area_avg_scoreboard;
		bit [PIX_W-1:0] pixels [0:STORE_W*STORE_H-1];
		bit [REG_W-1:0] width_reg;
		bit [REG_W-1:0] height_reg;
		area_avg_t      pending_averages[$];
		int             errors;

		function new();
			width_reg  = REG_W'(RESET_SIZE);
			height_reg = REG_W'(RESET_SIZE);
			errors     = 0;
		endfunction

		// A zero register means one pixel; larger than the store saturates.
		function int clip_size(bit [REG_W-1:0] r, int maxv);
			if (r == 0)
				return 1;
			if (r > maxv)
				return maxv;
			return r;
		endfunction

		function int img_width();
			return clip_size(width_reg, STORE_W);
		endfunction

		function int img_height();
			return clip_size(height_reg, STORE_H);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		// Update the image on a write, or predict the average of a query.
		function void note_item(pixel_req_t r);
			int w, h, x0, y0, x1, y1, swap_tmp, count;
			int sum_r, sum_g, sum_b, sum_a;
			bit [PIX_W-1:0] p;
			area_avg_t res;
			w  = img_width();
			h  = img_height();
			x0 = r.ax;
			y0 = r.ay;
			x1 = r.bx;
			y1 = r.by;
			if (r.action == ACTION_WRITE) begin
				if (x0 >= 0 && x0 < w && y0 >= 0 && y0 < h)
					pixels[y0 * STORE_W + x0] = {r.alpha, r.blue, r.green, r.red};
				return;
			end
			if (x1 < x0) begin
				swap_tmp = x0; x0 = x1; x1 = swap_tmp;
			end
			if (y1 < y0) begin
				swap_tmp = y0; y0 = y1; y1 = swap_tmp;
			end
			res = '{default: '0};
			if (x1 < 0 || x0 >= w || y1 < 0 || y0 >= h) begin
				res.outside = 1'b1;
				pending_averages.push_back(res);
				return;
			end
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 >= w) x1 = w - 1;
			if (y1 >= h) y1 = h - 1;
			sum_r = 0; sum_g = 0; sum_b = 0; sum_a = 0;
			for (int y = y0; y <= y1; y++) begin
				for (int x = x0; x <= x1; x++) begin
					p = pixels[y * STORE_W + x];
					sum_r += p[7:0];
					sum_g += p[15:8];
					sum_b += p[23:16];
					sum_a += p[31:24];
				end
			end
			count     = (x1 - x0 + 1) * (y1 - y0 + 1);
			res.red   = CH_W'(sum_r / count);
			res.green = CH_W'(sum_g / count);
			res.blue  = CH_W'(sum_b / count);
			res.alpha = CH_W'(sum_a / count);
			pending_averages.push_back(res);
		endfunction

		// Compare one result transaction with the oldest prediction.
		function void check_result(area_avg_t got);
			area_avg_t exp_res;
			if (pending_averages.size() == 0) begin
				$error("result transaction with no query pending");
				errors++;
				return;
			end
			exp_res = pending_averages.pop_front();
			if (got.red !== exp_res.red) begin
				$error("avg_red: expected %0d, actual %0d", exp_res.red, got.red);
				errors++;
			end
			if (got.green !== exp_res.green) begin
				$error("avg_green: expected %0d, actual %0d", exp_res.green, got.green);
				errors++;
			end
			if (got.blue !== exp_res.blue) begin
				$error("avg_blue: expected %0d, actual %0d", exp_res.blue, got.blue);
				errors++;
			end
			if (got.alpha !== exp_res.alpha) begin
				$error("avg_alpha: expected %0d, actual %0d", exp_res.alpha, got.alpha);
				errors++;
			end
			if (got.outside !== exp_res.outside) begin
				$error("outside: expected %0d, actual %0d", exp_res.outside, got.outside);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [REG_W-1:0]          cfg_data;
	logic                      req_valid;
	logic                      req_ready;
	logic                      action;
	logic signed [COORD_W-1:0] corner_a_x;
	logic signed [COORD_W-1:0] corner_a_y;
	logic signed [COORD_W-1:0] corner_b_x;
	logic signed [COORD_W-1:0] corner_b_y;
	logic [CH_W-1:0]           in_red;
	logic [CH_W-1:0]           in_green;
	logic [CH_W-1:0]           in_blue;
	logic [CH_W-1:0]           in_alpha;
	logic                      res_valid;
	logic                      res_ready;
	logic [CH_W-1:0]           avg_red;
	logic [CH_W-1:0]           avg_green;
	logic [CH_W-1:0]           avg_blue;
	logic [CH_W-1:0]           avg_alpha;
	logic                      outside;

	area_avg_scoreboard sb;
	bit                 steady;
	int                 cycle_count;

	rectangle_area_average_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.corner_a_x (corner_a_x),
		.corner_a_y (corner_a_y),
		.corner_b_x (corner_b_x),
		.corner_b_y (corner_b_y),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.in_alpha   (in_alpha),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.avg_red    (avg_red),
		.avg_green  (avg_green),
		.avg_blue   (avg_blue),
		.avg_alpha  (avg_alpha),
		.outside    (outside)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit; a hang ends the run as a failure.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic bit idle_roll();
		return !steady && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Result side stalls at random unless a steady stretch is running.
	initial res_ready = 1'b0;
	always @(negedge clk) begin
		res_ready <= !idle_roll();
	end

	// Check every result transaction at the clock edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result('{avg_red, avg_green, avg_blue, avg_alpha, outside});
	end

	// Present one transaction and hold it until accepted; starts and ends
	// just after a falling edge.
	task automatic send_item(pixel_req_t r);
		while (idle_roll()) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		action     = r.action;
		corner_a_x = r.ax;
		corner_a_y = r.ay;
		corner_b_x = r.bx;
		corner_b_y = r.by;
		in_red     = r.red;
		in_green   = r.green;
		in_blue    = r.blue;
		in_alpha   = r.alpha;
		req_valid  = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_item(r);
		@(negedge clk);
	endtask

	// Let every pending query finish, then give the block time to settle.
	task automatic drain();
		req_valid = 1'b0;
		while (sb.pending_averages.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_size(int w_reg, int h_reg);
		drain();
		cfg_we    = 1'b1;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data  = REG_W'(w_reg);
		@(negedge clk);
		cfg_index = REG_IMAGE_HEIGHT;
		cfg_data  = REG_W'(h_reg);
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(REG_IMAGE_WIDTH, REG_W'(w_reg));
		sb.write_reg(REG_IMAGE_HEIGHT, REG_W'(h_reg));
	endtask

	function automatic pixel_req_t pixel_write(int x, int y, int r, int g, int b, int a);
		pixel_req_t t;
		t.action = ACTION_WRITE;
		t.ax     = 16'(x);
		t.ay     = 16'(y);
		t.bx     = 16'($urandom);
		t.by     = 16'($urandom);
		t.red    = 8'(r);
		t.green  = 8'(g);
		t.blue   = 8'(b);
		t.alpha  = 8'(a);
		return t;
	endfunction

	function automatic pixel_req_t rect_query(int ax, int ay, int bx, int by);
		pixel_req_t t;
		t.action = ACTION_QUERY;
		t.ax     = 16'(ax);
		t.ay     = 16'(ay);
		t.bx     = 16'(bx);
		t.by     = 16'(by);
		t.red    = 8'($urandom);
		t.green  = 8'($urandom);
		t.blue   = 8'($urandom);
		t.alpha  = 8'($urandom);
		return t;
	endfunction

	// Write every pixel of the current image so any query reads known data.
	task automatic fill_image();
		for (int y = 0; y < sb.img_height(); y++)
			for (int x = 0; x < sb.img_width(); x++)
				send_item(pixel_write(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255)));
	endtask

	// Random pixel write: mostly inside the image, some just off its edge,
	// some anywhere in the coordinate range.
	function automatic pixel_req_t random_write(int w, int h);
		int x, y, pick, lvl;
		pick = $urandom_range(0, 9);
		x = $urandom_range(0, w - 1);
		y = $urandom_range(0, h - 1);
		if (pick == 0) begin
			x = $urandom;
			y = $urandom;
		end else if (pick == 1) begin
			if ($urandom_range(0, 1))
				x = $urandom_range(0, 1) ? -1 : w;
			else
				y = $urandom_range(0, 1) ? -1 : h;
		end
		if ($urandom_range(0, 7) == 0) begin
			lvl = $urandom_range(0, 1) ? 255 : 0;
			return pixel_write(x, y, lvl, lvl, lvl, lvl);
		end
		return pixel_write(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	// Random query: mostly small rectangles near or across the image, plus ones
	// that miss it, span everything, lie inside it, or take any corners.
	function automatic pixel_req_t random_query(int w, int h);
		int ax, ay, bx, by, pick;
		pick = $urandom_range(0, 9);
		ax = $urandom_range(0, w + 3) - 2;
		ay = $urandom_range(0, h + 3) - 2;
		bx = ax + $urandom_range(0, 8) - 4;
		by = ay + $urandom_range(0, 8) - 4;
		case (pick)
			0: begin
				ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: begin
						bx = -1 - $urandom_range(0, 40);
						ax = bx - $urandom_range(0, 20);
					end
					1: begin
						ax = w + $urandom_range(0, 40);
						bx = ax + $urandom_range(0, 20);
					end
					2: begin
						by = -1 - $urandom_range(0, 40);
						ay = by - $urandom_range(0, 20);
					end
					default: begin
						ay = h + $urandom_range(0, 40);
						by = ay + $urandom_range(0, 20);
					end
				endcase
			end
			2: begin
				ax = -32768; bx = 32767;
				ay = -32768; by = 32767;
			end
			3: begin
				ax = $urandom_range(0, w - 1);
				bx = $urandom_range(0, w - 1);
				ay = $urandom_range(0, h - 1);
				by = $urandom_range(0, h - 1);
			end
			default: ;
		endcase
		if ($urandom_range(0, 1))
			return rect_query(bx, by, ax, ay);
		return rect_query(ax, ay, bx, by);
	endfunction

	// Image sizes visited by the random part, register values as written.
	int phase_w[NUM_PHASES] = '{7, 1, 6, 0, 9, 3, 12, 5};
	int phase_h[NUM_PHASES] = '{5, 12, 4, 2, 1, 7, 3, 0};

	initial begin
		sb         = new();
		steady     = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_IMAGE_WIDTH;
		cfg_data   = '0;
		req_valid  = 1'b0;
		action     = ACTION_WRITE;
		corner_a_x = '0;
		corner_a_y = '0;
		corner_b_x = '0;
		corner_b_y = '0;
		in_red     = '0;
		in_green   = '0;
		in_blue    = '0;
		in_alpha   = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset size of 256 by 256: rectangles past the far edge miss,
		// the far corner pixel is reachable, writes off the image are dropped.
		send_item(rect_query(256, 0, 400, 3));
		send_item(rect_query(5, 300, 0, 256));
		send_item(pixel_write(255, 255, 8'h12, 8'h34, 8'h56, 8'h78));
		send_item(pixel_write(-1, -1, 255, 255, 255, 255));
		send_item(pixel_write(256, 7, 255, 255, 255, 255));
		send_item(rect_query(255, 255, 255, 255));
		send_item(rect_query(32767, 32767, 255, 255));

		// Size registers above the store saturate to 256 by 256.
		set_size(511, 300);
		send_item(pixel_write(300, 0, 255, 255, 255, 255));
		send_item(rect_query(255, 255, 300, 300));
		send_item(rect_query(256, 0, 510, 0));
		send_item(rect_query(0, 299, 0, 256));

		// Zero in both size registers gives a one-pixel image.
		set_size(0, 0);
		send_item(pixel_write(0, 0, 255, 255, 255, 255));
		send_item(rect_query(-32768, -32768, 32767, 32767));
		send_item(rect_query(32767, 32767, -32768, -32768));
		send_item(rect_query(1, 0, 5, 0));
		send_item(rect_query(-5, -5, -1, 0));
		send_item(rect_query(0, -3, 0, -1));

		// Small image: swapped corners, clamping on each side, edge misses.
		set_size(4, 3);
		fill_image();
		send_item(pixel_write(3, 2, 0, 0, 0, 0));
		send_item(pixel_write(0, 0, 255, 255, 255, 255));
		send_item(rect_query(0, 0, 3, 2));
		send_item(rect_query(3, 2, 0, 0));
		send_item(rect_query(-100, 1, 100, 1));
		send_item(rect_query(1, 9, 1, -9));
		send_item(rect_query(4, 0, 9, 2));
		send_item(rect_query(0, 3, 3, 9));
		send_item(rect_query(2, 1, 2, 1));

		// Random part, one image size per phase; one phase runs with no stalls.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_size(phase_w[p], phase_h[p]);
			fill_image();
			steady = (p == 3);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) < 40)
					send_item(random_write(sb.img_width(), sb.img_height()));
				else
					send_item(random_query(sb.img_width(), sb.img_height()));
			end
			steady = 1'b0;
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending_averages.size() != 0) begin
			$error("%0d query results never arrived", sb.pending_averages.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
